[rtl/assert_macros.svh]
// Assertion macros shared by the accumulator RTL.
// Depends on nothing; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/glla_pkg.sv]
// Types and fixed constants for the Gaussian log-likelihood accumulator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package glla_pkg;

    localparam int LOG_FB = 24;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [63:0] HALF_LN_2PI_Q32 = 64'd3946810947;
    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] mu;
        logic [30:0]        s;
        logic               last;
        logic               mode;
        logic               bad;
    } t_elem;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_NORM,
        LN_SQ,
        LN_MUL
    } t_ln_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_N_LNS,
        S_N_DIV,
        S_N_SQ,
        S_N_TERM,
        S_L_LNM,
        S_L_MM,
        S_L_SS,
        S_L_LNK,
        S_L_LNX,
        S_L_W,
        S_L_SQ,
        S_L_DIV,
        S_L_LNV,
        S_L_TERM,
        S_ACC,
        S_DONE,
        S_EMIT
    } t_bk_state;

endpackage

[rtl/glla_front.sv]
// Front end: takes input requests, classifies them and queues them for the back end.
// Depends on glla_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glla_front import glla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [95:0] i_data,
    input  logic        i_last,
    output logic        o_q_valid,
    output t_elem       o_q_elem,
    input  logic        i_q_pop
);

    logic        r_mode;
    t_elem       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_elem       w_elem;
    logic        w_push;
    logic [30:0] w_s;

    always_comb begin
        w_s           = i_data[94:64];
        w_elem.x      = $signed(i_data[31:0]);
        w_elem.mu     = $signed(i_data[63:32]);
        // A zero deviation is taken as one LSB.
        w_elem.s      = (w_s == 31'd0) ? 31'd1 : w_s;
        w_elem.last   = i_last;
        w_elem.mode   = r_mode;
        w_elem.bad    = r_mode && (i_data[31] || (i_data[31:0] == 32'd0));
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_elem  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_elem;
        end
    end

    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_q_pop && (r_cnt == 2'd0))
    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3)
    `ASSERT_PROP(a_push_grows, i_clk, i_rst_n, (w_push && !i_q_pop) |=> (r_cnt != 2'd0))

endmodule

[rtl/glla_ln.sv]
// Iterative natural logarithm unit: normalise, square for fraction bits, scale by ln 2.
// Depends on glla_pkg.
`timescale 1ns / 1ps
module glla_ln import glla_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_u,
    input  logic               i_dbl,
    output logic               o_done,
    output logic signed [31:0] o_res
);

    localparam int RSH = 32 + LOG_FB - FRAC_BITS;

    t_ln_state          r_state, n_state;
    logic [63:0]        r_u;
    logic [5:0]         r_p;
    logic               r_dbl;
    logic [30:0]        r_m;
    logic [LOG_FB-1:0]  r_f;
    logic [4:0]         r_cnt;
    logic [63:0]        r_prod;
    logic               r_neg;
    logic               r_done;

    logic [61:0]        w_sq;
    logic [31:0]        w_t;
    logic signed [7:0]  w_pb;
    logic signed [31:0] w_ftot;
    logic [31:0]        w_fabs;
    logic [63:0]        w_rnd;

    always_comb begin
        w_sq   = 62'(r_m) * 62'(r_m);
        w_t    = w_sq[61:30];
        w_pb   = $signed({2'b00, r_p}) - (r_dbl ? 8'(2 * FRAC_BITS) : 8'(FRAC_BITS));
        w_ftot = $signed({w_pb, {LOG_FB{1'b0}}}) + $signed({8'd0, r_f});
        w_fabs = w_ftot[31] ? 32'(-w_ftot) : 32'(w_ftot);
        w_rnd  = (r_prod + (64'd1 << (RSH - 1))) >> RSH;
        o_res  = r_neg ? -$signed(w_rnd[31:0]) : $signed(w_rnd[31:0]);
    end

    assign o_done = r_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            LN_IDLE: if (i_start) n_state = LN_NORM;
            LN_NORM: if (r_u[63]) n_state = LN_SQ;
            LN_SQ:   if (r_cnt == 5'(LOG_FB - 1)) n_state = LN_MUL;
            LN_MUL:  n_state = LN_IDLE;
            default: n_state = LN_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == LN_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            LN_IDLE: begin
                r_u   <= i_u;
                r_p   <= 6'd63;
                r_dbl <= i_dbl;
            end
            LN_NORM: begin
                // Coarse byte steps first, then single bits, until the top bit is set.
                if (r_u[63:56] == 8'd0) begin
                    r_u <= r_u << 8;
                    r_p <= r_p - 6'd8;
                end else if (!r_u[63]) begin
                    r_u <= r_u << 1;
                    r_p <= r_p - 6'd1;
                end else begin
                    r_m   <= r_u[63:33];
                    r_f   <= '0;
                    r_cnt <= 5'd0;
                end
            end
            LN_SQ: begin
                r_cnt <= r_cnt + 5'd1;
                if (w_t[31]) begin
                    r_m <= w_t[31:1];
                    r_f <= {r_f[LOG_FB-2:0], 1'b1};
                end else begin
                    r_m <= w_t[30:0];
                    r_f <= {r_f[LOG_FB-2:0], 1'b0};
                end
            end
            LN_MUL: begin
                r_prod <= 64'(w_fabs) * 64'(LN2_Q32);
                r_neg  <= w_ftot[31];
            end
            default: begin
                r_u <= r_u;
            end
        endcase
    end

endmodule

[rtl/glla_div.sv]
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on glla_pkg.
`timescale 1ns / 1ps
module glla_div import glla_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num, r_rem, r_den;
    logic [64:0] w_sh, w_diff;

    assign w_sh   = {r_rem, r_num[63]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient bits shift into the numerator register as it empties.
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_start) begin
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
            end
        end else if (!w_diff[64]) begin
            r_rem <= w_diff[63:0];
            r_num <= {r_num[62:0], 1'b1};
        end else begin
            r_rem <= w_sh[63:0];
            r_num <= {r_num[62:0], 1'b0};
        end
    end

endmodule

[rtl/glla_back.sv]
// Back end: sequences one element through the log unit, divider and multiplier,
// accumulates with saturation and holds the result register. Depends on glla_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module glla_back import glla_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_elem                i_q_elem,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [ACC_WIDTH-1:0] o_data,
    output logic                 o_fail
);

    localparam logic [63:0] C_Q =
        (HALF_LN_2PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    t_bk_state                    r_state, n_state;
    logic                         r_busy, n_busy;
    t_elem                        r_e;
    logic signed [31:0]           r_l1, r_lx, r_lv;
    logic [33:0]                  r_v;
    logic [30:0]                  r_wm;
    logic [61:0]                  r_prod, r_k;
    logic [63:0]                  r_h;
    logic signed [63:0]           r_term;
    logic signed [ACC_WIDTH-1:0]  r_acc;
    logic                         r_failed;
    logic                         r_ovalid, r_ouser;
    logic [ACC_WIDTH-1:0]         r_odata;

    logic                         ln_start, ln_dbl, ln_done;
    logic [63:0]                  ln_u;
    logic signed [31:0]           ln_res;
    logic                         div_start, div_done;
    logic [63:0]                  div_num, div_den, div_quo;
    logic [30:0]                  w_m;
    logic signed [32:0]           w_z;
    logic [32:0]                  w_az;
    logic signed [33:0]           w_v;
    logic signed [63:0]           w_w;
    logic [31:0]                  w_lvm;
    logic [32:0]                  w_rs;
    logic signed [63:0]           w_rss;
    logic [63:0]                  w_hn;
    logic signed [64:0]           w_sum;
    logic                         w_load;

    glla_ln #(.FRAC_BITS(FRAC_BITS)) u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ln_start),
        .i_u     (ln_u),
        .i_dbl   (ln_dbl),
        .o_done  (ln_done),
        .o_res   (ln_res)
    );

    glla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        // A non-positive lognormal mean is taken as one LSB.
        w_m   = (!r_e.mu[31] && (r_e.mu != 32'sd0)) ? r_e.mu[30:0] : 31'd1;
        w_z   = 33'(r_e.x) - 33'(r_e.mu);
        w_az  = w_z[32] ? 33'(-w_z) : 33'(w_z);
        w_v   = $signed({{2{ln_res[31]}}, ln_res}) - $signed({r_l1[31], r_l1, 1'b0});
        w_w   = (64'(r_lx) <<< 1) - (64'(r_l1) <<< 1) + $signed(64'(r_v));
        w_lvm = r_lv[31] ? 32'(-r_lv) : 32'(r_lv);
        w_rs  = (33'(w_lvm) + 33'd1) >> 1;
        w_rss = r_lv[31] ? -$signed(64'(w_rs)) : $signed(64'(w_rs));
        w_hn  = (64'(r_prod) + (64'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
        w_sum = $signed({{(65-ACC_WIDTH){r_acc[ACC_WIDTH-1]}}, r_acc})
              + $signed({r_term[63], r_term});
        w_load = !r_ovalid || i_ready;
    end

    always_comb begin
        n_state   = r_state;
        n_busy    = r_busy;
        o_q_pop   = 1'b0;
        ln_start  = 1'b0;
        ln_u      = 64'(r_e.s);
        ln_dbl    = 1'b0;
        div_start = 1'b0;
        div_num   = 64'(w_az) << FRAC_BITS;
        div_den   = 64'(r_e.s);
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (r_failed || i_q_elem.bad) begin
                        n_state = S_DONE;
                    end else if (!i_q_elem.mode) begin
                        n_state = S_N_LNS;
                    end else begin
                        n_state = S_L_LNM;
                    end
                end
            end
            S_N_LNS: begin
                ln_start = !r_busy;
                n_busy   = 1'b1;
                if (ln_done) begin
                    n_busy  = 1'b0;
                    n_state = S_N_DIV;
                end
            end
            S_N_DIV: begin
                div_start = !r_busy;
                n_busy    = 1'b1;
                if (div_done) begin
                    n_busy  = 1'b0;
                    n_state = S_N_SQ;
                end
            end
            S_N_SQ:   n_state = S_N_TERM;
            S_N_TERM: n_state = S_ACC;
            S_L_LNM: begin
                ln_u     = 64'(w_m);
                ln_start = !r_busy;
                n_busy   = 1'b1;
                if (ln_done) begin
                    n_busy  = 1'b0;
                    n_state = S_L_MM;
                end
            end
            S_L_MM: n_state = S_L_SS;
            S_L_SS: n_state = S_L_LNK;
            S_L_LNK: begin
                ln_u     = 64'(r_k) + 64'(r_prod);
                ln_dbl   = 1'b1;
                ln_start = !r_busy;
                n_busy   = 1'b1;
                if (ln_done) begin
                    n_busy  = 1'b0;
                    n_state = S_L_LNX;
                end
            end
            S_L_LNX: begin
                ln_u     = 64'(r_e.x[30:0]);
                ln_start = !r_busy;
                n_busy   = 1'b1;
                if (ln_done) begin
                    n_busy  = 1'b0;
                    n_state = S_L_W;
                end
            end
            S_L_W:  n_state = S_L_SQ;
            S_L_SQ: n_state = S_L_DIV;
            S_L_DIV: begin
                div_num   = 64'(r_prod) + (64'(r_v) << 2);
                div_den   = 64'(r_v) << 3;
                div_start = !r_busy;
                n_busy    = 1'b1;
                if (div_done) begin
                    n_busy  = 1'b0;
                    n_state = S_L_LNV;
                end
            end
            S_L_LNV: begin
                ln_u     = 64'(r_v);
                ln_start = !r_busy;
                n_busy   = 1'b1;
                if (ln_done) begin
                    n_busy  = 1'b0;
                    n_state = S_L_TERM;
                end
            end
            S_L_TERM: n_state = S_ACC;
            S_ACC:    n_state = S_DONE;
            S_DONE:   n_state = r_e.last ? S_EMIT : S_IDLE;
            S_EMIT:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_acc    <= '0;
            r_failed <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            if (r_state == S_EMIT && w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_IDLE && i_q_valid && !r_failed && i_q_elem.bad) begin
                r_failed <= 1'b1;
            end
            if (r_state == S_ACC) begin
                if (w_sum > $signed(65'(ACC_MAX))) begin
                    r_acc <= ACC_MAX;
                end else if (w_sum < $signed(65'(ACC_MIN))) begin
                    r_acc <= ACC_MIN;
                end else begin
                    r_acc <= w_sum[ACC_WIDTH-1:0];
                end
            end
            if (r_state == S_EMIT && w_load) begin
                r_acc    <= '0;
                r_failed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid) begin
            r_e <= i_q_elem;
        end
        if (r_state == S_EMIT && w_load) begin
            r_odata <= r_failed ? ACC_MIN : r_acc;
            r_ouser <= r_failed;
        end
        case (r_state)
            S_N_LNS: if (ln_done) r_l1 <= ln_res;
            S_N_DIV: if (div_done) r_wm <= (div_quo > 64'(SAT31)) ? SAT31 : div_quo[30:0];
            S_N_SQ:  r_prod <= 62'(r_wm) * 62'(r_wm);
            S_N_TERM: r_term <= -$signed(C_Q) - 64'(r_l1) - $signed(w_hn);
            S_L_LNM: if (ln_done) r_l1 <= ln_res;
            S_L_MM:  r_prod <= 62'(w_m) * 62'(w_m);
            S_L_SS: begin
                r_k    <= r_prod;
                r_prod <= 62'(r_e.s) * 62'(r_e.s);
            end
            S_L_LNK: begin
                // A variance below one LSB is raised to one LSB.
                if (ln_done) r_v <= (w_v < 34'sd1) ? 34'd1 : 34'(w_v);
            end
            S_L_LNX: if (ln_done) r_lx <= ln_res;
            S_L_W: begin
                if (w_w > $signed(64'(SAT31))) begin
                    r_wm <= SAT31;
                end else if (w_w < -$signed(64'(SAT31))) begin
                    r_wm <= SAT31;
                end else begin
                    r_wm <= w_w[63] ? 31'(-w_w) : w_w[30:0];
                end
            end
            S_L_SQ:  r_prod <= 62'(r_wm) * 62'(r_wm);
            S_L_DIV: if (div_done) r_h <= div_quo;
            S_L_LNV: if (ln_done) r_lv <= ln_res;
            S_L_TERM: r_term <= -64'(r_lx) - $signed(C_Q) - w_rss - $signed(r_h);
            default: r_term <= r_term;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_fail  = r_ouser;

    `ASSERT_PROP(a_fail_min, i_clk, i_rst_n, (r_ovalid && r_ouser) |-> (r_odata == ACC_MIN))
    `ASSERT_PROP(a_emit_clear, i_clk, i_rst_n, (r_state == S_EMIT && w_load) |=> (r_acc == '0 && !r_failed))
    `ASSERT_NEVER(a_unit_clash, i_clk, i_rst_n, ln_start && div_start)

endmodule

[rtl/gaussian_log_likelihood_accumulator.sv]
// A normal element takes one pass of the log unit and one division;
// a lognormal element takes four passes of the log unit plus one division.
// The back end takes one element at a time; a two-deep queue keeps input
// requests flowing, and the output register lets the result wait for the sink.
// Reset (i_rst_n, synchronous, active low) clears the sum, the failure flag and the mode.
`timescale 1ns / 1ps
module gaussian_log_likelihood_accumulator import glla_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_WIDTH = 48
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample_value [31:0], mean_value [63:32], std_dev [94:64], zero [95]
    input  logic [95:0]                        s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // log_prob [ACC_WIDTH-1:0], zero padding above
    output logic [((ACC_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // fail_flag [0]
    output logic                               m_axis_tuser
);

    localparam int OUT_W = ((ACC_WIDTH + 7) / 8) * 8;

    logic                 q_valid, q_pop;
    t_elem                q_elem;
    logic [ACC_WIDTH-1:0] w_data;

    glla_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_q_valid   (q_valid),
        .o_q_elem    (q_elem),
        .i_q_pop     (q_pop)
    );

    glla_back #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_elem  (q_elem),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (w_data),
        .o_fail    (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'(w_data);

endmodule
